@@ rtl/core/xtea_pkg.sv @@
// shared types and constants for the xtea block cipher unit
package xtea_pkg;

  // golden-ratio increment of the round sum
  localparam logic [31:0] DELTA = 32'h9E37_79B9;

  // reset value of the round count register
  localparam logic [7:0] DEFAULT_ROUNDS = 8'd64;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_ROUNDS = 3'd4
  } reg_index_t;

  // input item: mode and the two block halves
  typedef struct packed {
    logic        mode;
    logic [31:0] word_low;
    logic [31:0] word_high;
  } in_item_t;

  // result item: the two block halves
  typedef struct packed {
    logic [31:0] out_low;
    logic [31:0] out_high;
  } out_item_t;

  // control of the shared half-round unit
  typedef struct packed {
    logic decipher;
    logic phase;
  } round_ctl_t;

endpackage

@@ rtl/core/xtea_round.sv @@
// shared xtea half-round unit: one mix and one add or subtract
module xtea_round (
  input  logic [31:0]          y,
  input  logic [31:0]          z,
  input  logic [31:0]          sum,
  input  logic [3:0][31:0]     key,
  input  xtea_pkg::round_ctl_t ctl,
  output logic [31:0]          result
);

  logic        upd_z;
  logic [31:0] src;
  logic [31:0] tgt;
  logic [1:0]  ksel;
  logic [31:0] feistel;
  logic [31:0] mix;

  // which half is updated, and which feeds the mix
  assign upd_z = ctl.decipher ^ ctl.phase;
  assign src   = upd_z ? y : z;
  assign tgt   = upd_z ? z : y;
  assign ksel  = upd_z ? sum[12:11] : sum[1:0];

  // mix function of the source half
  assign feistel = ((src << 4) ^ (src >> 5)) + src;
  assign mix     = feistel ^ (sum + key[ksel]);

  // forward adds, reverse subtracts
  assign result = ctl.decipher ? (tgt - mix) : (tgt + mix);

endmodule

@@ rtl/core/xtea_block_cipher_unit.sv @@
// top level of the xtea block cipher unit: config, sequencer, output register
//
//  channel  | ports                          | direction | content
//  ---------+--------------------------------+-----------+---------------------------
//  input    | in_valid, in_stall, in_item    | in        | mode, word_low, word_high
//  result   | out_valid, out_stall, out_item | out       | out_low, out_high
//  config   | cfg_we, cfg_index, cfg_wdata   | in        | key words, round count
//
// one item is taken from accept through the half-round steps into the result register,
// and the next item is accepted only once the sequencer is back in idle:
// the single half-round unit runs one half of an xtea cycle per clock.
// a round count of zero gives the block back unchanged.
// in_stall is high from the accept until the result is placed in the output register.
// the output register holds one result while the next item is accepted and worked on;
// a finished item waits, with the input stalled, while that result is still stalled.
// synchronous active-low reset clears control state and loads the register defaults.
module xtea_block_cipher_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  xtea_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output xtea_pkg::out_item_t  out_item,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                state_r, state_nxt;
  logic [3:0][31:0]      key_r;
  logic [7:0]            rounds_r;
  logic [31:0]           y_r, z_r, sum_r;
  logic [7:0]            rem_r;
  logic                  phase_r;
  logic                  decipher_r;
  logic                  out_valid_r;
  xtea_pkg::out_item_t   out_item_r;

  logic                  accept;
  logic                  out_free;
  logic                  finish;
  logic                  step;
  logic [31:0]           sum_start;
  logic [31:0]           round_res;
  xtea_pkg::round_ctl_t  ctl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r    <= '0;
      rounds_r <= xtea_pkg::DEFAULT_ROUNDS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        xtea_pkg::REG_KEY0:   key_r[0] <= cfg_wdata;
        xtea_pkg::REG_KEY1:   key_r[1] <= cfg_wdata;
        xtea_pkg::REG_KEY2:   key_r[2] <= cfg_wdata;
        xtea_pkg::REG_KEY3:   key_r[3] <= cfg_wdata;
        xtea_pkg::REG_ROUNDS: rounds_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // handshake and sequencing conditions
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign finish    = (state_r == ST_RUN) && (rem_r == '0) && out_free;
  assign step      = (state_r == ST_RUN) && (rem_r != '0);
  assign in_stall  = (state_r != ST_IDLE);

  // reverse direction starts from delta times the cycle count
  assign sum_start = xtea_pkg::DELTA * {24'd0, rounds_r};

  // shared half-round unit
  assign ctl.decipher = decipher_r;
  assign ctl.phase    = phase_r;

  xtea_round u_round (
    .y      (y_r),
    .z      (z_r),
    .sum    (sum_r),
    .key    (key_r),
    .ctl    (ctl),
    .result (round_res)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_RUN;
      ST_RUN:  if (finish) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // working block, sum and remaining cycle count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r      <= '0;
      phase_r    <= 1'b0;
      decipher_r <= 1'b0;
    end else if (accept) begin
      rem_r      <= rounds_r;
      phase_r    <= 1'b0;
      decipher_r <= in_item.mode;
    end else if (step) begin
      phase_r <= !phase_r;
      if (phase_r) begin
        rem_r <= rem_r - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      y_r   <= in_item.word_low;
      z_r   <= in_item.word_high;
      sum_r <= in_item.mode ? sum_start : 32'd0;
    end else if (step) begin
      if (decipher_r ^ phase_r) begin
        z_r <= round_res;
      end else begin
        y_r <= round_res;
      end
      // sum moves between the two halves of a cycle
      if (!phase_r) begin
        sum_r <= decipher_r ? (sum_r - xtea_pkg::DELTA) : (sum_r + xtea_pkg::DELTA);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_item_r.out_low  <= y_r;
      out_item_r.out_high <= z_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/core/xtea_checker.sv @@
// port-level checks of the xtea block cipher unit and their binding
module xtea_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input xtea_pkg::out_item_t out_item
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // no result appears the cycle right after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result too early after accept");

  // reset empties the output and frees the input
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("state not cleared by reset");

endmodule

bind xtea_block_cipher_unit xtea_checker u_xtea_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
